// ===== src/exps_pkg.sv =====
// Shared types, constants and the event rewrite table of the exclusion-process event engine.
package exps_pkg;

   localparam int DEFAULT_SITES = 1024;
   localparam int GHOST_SLOTS   = 3;
   localparam int RATE_W        = 16;
   localparam int FRAC_W        = 32;
   localparam int TOTAL_W       = 29;
   localparam int SITE_OUT_W    = 10;
   localparam int CSR_INDEX_W   = 3;
   localparam int OP_COUNT      = 9;
   localparam int OP_W          = 4;
   localparam longint RATE_MAX  = 65535;
   localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;

   localparam logic CMD_INIT = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   typedef enum logic [1:0] {
      KIND_BIND    = 2'd0,
      KIND_UNBIND  = 2'd1,
      KIND_HOP     = 2'd2,
      KIND_RECOVER = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BIND    = 3'd0,
      CSR_REBIND  = 3'd1,
      CSR_UNBIND  = 3'd2,
      CSR_HOP     = 3'd3,
      CSR_RECOVER = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      OFF_LEFT  = 2'd0,
      OFF_HERE  = 2'd1,
      OFF_RIGHT = 2'd2
   } off_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_ROOT,
      ST_MUL,
      ST_DESC,
      ST_OCC,
      ST_LEAF_RD,
      ST_LEAF,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [RATE_W-1:0] bind_rate;
      logic [RATE_W-1:0] rebind_rate;
      logic [RATE_W-1:0] unbind_rate;
      logic [RATE_W-1:0] hop_rate;
      logic [RATE_W-1:0] recover_rate;
   } rates_type;

   typedef struct packed {
      logic              valid;
      off_type           off;
      kind_type          act;
      logic [RATE_W-1:0] value;
      logic              occ_wr;
      logic              occ_val;
   } op_type;

   function automatic op_type mk_op(off_type off, kind_type act, logic [RATE_W-1:0] value,
                                    logic occ_wr, logic occ_val);
      op_type o;
      o.valid   = 1'b1;
      o.off     = off;
      o.act     = act;
      o.value   = value;
      o.occ_wr  = occ_wr;
      o.occ_val = occ_val;
      return o;
   endfunction

   // occ: bit 0 site to the left, bit 1 site to the right, bit 2 two sites to the right
   function automatic op_type event_op(kind_type kind, logic [OP_W-1:0] idx, logic [2:0] occ,
                                       rates_type r);
      op_type o;
      logic [RATE_W-1:0] left_hop;
      o        = '0;
      o.off    = OFF_HERE;
      o.act    = KIND_BIND;
      left_hop = occ[0] ? r.hop_rate : '0;
      case (kind)
         KIND_BIND: begin
            case (idx)
               4'd0:    o = mk_op(OFF_LEFT, KIND_HOP, '0, 1'b0, 1'b0);
               4'd1:    o = mk_op(OFF_HERE, KIND_BIND, '0, 1'b1, 1'b1);
               4'd2:    o = mk_op(OFF_HERE, KIND_UNBIND, r.unbind_rate, 1'b0, 1'b0);
               4'd3:    o = mk_op(OFF_HERE, KIND_HOP, occ[1] ? '0 : r.hop_rate, 1'b0, 1'b0);
               4'd4:    o = mk_op(OFF_HERE, KIND_RECOVER, '0, 1'b0, 1'b0);
               default: o.valid = 1'b0;
            endcase
         end
         KIND_UNBIND, KIND_HOP: begin
            case (idx)
               4'd0:    o = mk_op(OFF_LEFT, KIND_HOP, left_hop, 1'b0, 1'b0);
               4'd1:    o = mk_op(OFF_HERE, KIND_BIND, r.rebind_rate, 1'b1, 1'b0);
               4'd2:    o = mk_op(OFF_HERE, KIND_UNBIND, '0, 1'b0, 1'b0);
               4'd3:    o = mk_op(OFF_HERE, KIND_HOP, '0, 1'b0, 1'b0);
               4'd4:    o = mk_op(OFF_HERE, KIND_RECOVER, r.recover_rate, 1'b0, 1'b0);
               4'd5:    o = mk_op(OFF_RIGHT, KIND_BIND, '0, 1'b1, 1'b1);
               4'd6:    o = mk_op(OFF_RIGHT, KIND_UNBIND, r.unbind_rate, 1'b0, 1'b0);
               4'd7:    o = mk_op(OFF_RIGHT, KIND_HOP, occ[2] ? '0 : r.hop_rate, 1'b0, 1'b0);
               4'd8:    o = mk_op(OFF_RIGHT, KIND_RECOVER, '0, 1'b0, 1'b0);
               default: o.valid = 1'b0;
            endcase
            if (kind == KIND_UNBIND && idx > 4'd4) begin
               o.valid = 1'b0;
            end
         end
         default: begin
            case (idx)
               4'd0:    o = mk_op(OFF_HERE, KIND_BIND, r.bind_rate, 1'b0, 1'b0);
               4'd1:    o = mk_op(OFF_HERE, KIND_UNBIND, '0, 1'b0, 1'b0);
               4'd2:    o = mk_op(OFF_HERE, KIND_HOP, '0, 1'b0, 1'b0);
               4'd3:    o = mk_op(OFF_HERE, KIND_RECOVER, '0, 1'b0, 1'b0);
               default: o.valid = 1'b0;
            endcase
         end
      endcase
      return o;
   endfunction

endpackage

// ===== src/exps_tree_ram.sv =====
// Rate sum tree memory: one write port, one read port, registered read data.
module exps_tree_ram
   import exps_pkg::*;
#(
   parameter int AW = 14,
   parameter int DW = 30
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/exps_sweep_calc.sv =====
// Value of one tree node after init: bind rate times the real bind entries below it.
module exps_sweep_calc
   import exps_pkg::*;
#(
   parameter int SITES = DEFAULT_SITES,
   parameter int LV    = 13,
   parameter int LW    = 4,
   parameter int SUM_W = 29
) (
   input  logic [LW-1:0]     level,
   input  logic [LV-1:0]     pos,
   input  logic [RATE_W-1:0] bind_rate,
   output logic [SUM_W-1:0]  value
);

   logic [LV:0] lo, hi, mlo, mhi, cnt;
   logic [LV:0] span;

   always_comb begin
      span = (LV+1)'(1) << (LW'(LV) - level);
      lo   = {1'b0, pos} << (LW'(LV) - level);
      hi   = lo + span - (LV+1)'(1);
      mlo  = (lo + (LV+1)'(3)) >> 2;
      mhi  = hi >> 2;
      if (mlo == '0) begin
         mlo = (LV+1)'(1);
      end
      if (mhi > (LV+1)'(SITES)) begin
         mhi = (LV+1)'(SITES);
      end
      cnt   = (mhi >= mlo) ? (mhi - mlo + (LV+1)'(1)) : '0;
      value = SUM_W'(cnt * bind_rate);
   end

endmodule

// ===== src/exclusion_process_event_step_top.sv =====
// Top level of the exclusion-process event engine: sequencer around the rate sum tree.
//
// The lattice rates live in one binary sum tree memory of 2*NLEAF words, NLEAF being
// 4*(SITES+3) rounded up to a power of two (8192 for 1024 sites); each leaf also carries the
// site occupancy bit on its bind entry. After the accepting beat a draw reads the total and
// scales the fraction (a zero total ends the draw with no event), descends the tree level by
// level (13 levels at 1024 sites), reads the neighbor occupancy, then steps through the nine
// rewrite slots, reads the entry of each slot that lands on a real site and, when that entry
// changes, writes it and carries the difference up to the root level by level, and finally
// hands the result over; the single read and write port of the tree memory sets the pace.
// An init command rewrites every node. After reset the same pass clears the tree, during which
// no item is accepted; configuration writes are taken at any time.
module exclusion_process_event_step_top
   import exps_pkg::*;
#(
   parameter int SITES = DEFAULT_SITES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,   // random_fraction[31:0]
   input  logic [0:0]             req_tuser,   // command[0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata,   // event_site[9:0], total_rate[38:10], zero[39]
   output logic [2:0]             rsp_tuser,   // event_kind[1:0], no_event[2]
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [RATE_W-1:0]      csr_data
);

   localparam int NSLOTS = SITES + GHOST_SLOTS;
   localparam int NENT   = 4 * NSLOTS;
   localparam int LV     = $clog2(NENT);
   localparam int NLEAF  = 1 << LV;
   localparam int AW     = LV + 1;
   localparam int SUM_W  = $clog2(longint'(NENT) * RATE_MAX + 1);
   localparam int DW     = SUM_W + 1;
   localparam int SLOT_W = LV - 2;
   localparam int LW     = $clog2(LV + 1);

   state_type state_ff, state_in;

   rates_type rates_ff, rates_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [SUM_W-1:0] total_ff, total_in;
   logic [FRAC_W+SUM_W-1:0] prod_ff, prod_in;
   logic [SUM_W-1:0] t_ff, t_in;
   logic [AW-1:0] node_ff, node_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [LV-1:0] ent_ff, ent_in;
   logic [2:0] occ_ff, occ_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic [SUM_W-1:0] delta_ff, delta_in;
   logic zero_ff, zero_in;
   logic [LW-1:0] d_ff, d_in;
   logic [LV-1:0] p_ff, p_in;
   kind_type res_kind_ff, res_kind_in;
   logic [SITE_OUT_W-1:0] res_site_ff, res_site_in;
   logic res_noev_ff, res_noev_in;
   logic rsp_valid_ff, rsp_valid_in;
   kind_type rsp_kind_ff, rsp_kind_in;
   logic [SITE_OUT_W-1:0] rsp_site_ff, rsp_site_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic rsp_noev_ff, rsp_noev_in;

   logic ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [DW-1:0] ram_wdata, ram_rdata;
   logic [SUM_W-1:0] rd_sum, sweep_value;

   logic [LV:0] pspan;
   logic sweep_plast, sweep_last;
   logic req_fire, rsp_free;
   logic go_left;
   logic [AW-1:0] child;
   logic [SLOT_W-1:0] slot, tslot, occ_slot;
   op_type op;
   logic op_ok, op_last, leaf_same;
   logic [DW-1:0] leaf_new;

   exps_tree_ram #(.AW(AW), .DW(DW)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   exps_sweep_calc #(.SITES(SITES), .LV(LV), .LW(LW), .SUM_W(SUM_W)) u_calc (
      .level     (d_ff),
      .pos       (p_ff),
      .bind_rate (rates_ff.bind_rate),
      .value     (sweep_value)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rd_sum     = ram_rdata[SUM_W-1:0];

   assign pspan       = (LV+1)'(1) << d_ff;
   assign sweep_plast = ({1'b0, p_ff} == pspan - (LV+1)'(1));
   assign sweep_last  = (d_ff == LW'(LV)) && sweep_plast;

   assign go_left = (t_ff < rd_sum);
   assign child   = {node_ff[AW-2:0], ~go_left};

   assign slot = ent_ff[LV-1:2];
   assign op   = event_op(kind_type'(ent_ff[1:0]), op_ff, occ_ff, rates_ff);

   always_comb begin
      case (op.off)
         OFF_LEFT:  tslot = slot - SLOT_W'(1);
         OFF_RIGHT: tslot = slot + SLOT_W'(1);
         default:   tslot = slot;
      endcase
      case (cnt_ff)
         2'd0:    occ_slot = slot - SLOT_W'(1);
         2'd1:    occ_slot = slot + SLOT_W'(1);
         default: occ_slot = slot + SLOT_W'(2);
      endcase
   end

   assign op_ok     = op.valid && (tslot != '0) && (tslot <= SLOT_W'(SITES));
   assign op_last   = (op_ff == OP_W'(OP_COUNT - 1));
   assign leaf_new  = {op.occ_wr ? op.occ_val : ram_rdata[DW-1], SUM_W'(op.value)};
   assign leaf_same = (leaf_new == ram_rdata);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = zero_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_tuser[0] == CMD_INIT) ? ST_SWEEP : ST_ROOT;
            end
         end
         ST_ROOT:    state_in = (rd_sum == '0) ? ST_DONE : ST_MUL;
         ST_MUL:     state_in = ST_DESC;
         ST_DESC: begin
            if (lvl_ff == LW'(LV - 1)) begin
               state_in = ST_OCC;
            end
         end
         ST_OCC: begin
            if (cnt_ff == 2'd3) begin
               state_in = ST_LEAF_RD;
            end
         end
         ST_LEAF_RD: begin
            if (op_ok) begin
               state_in = ST_LEAF;
            end else if (op_last) begin
               state_in = ST_DONE;
            end
         end
         ST_LEAF: begin
            if (!leaf_same) begin
               state_in = ST_WALK;
            end else begin
               state_in = op_last ? ST_DONE : ST_LEAF_RD;
            end
         end
         ST_WALK: begin
            if (node_ff == AW'(1)) begin
               state_in = op_last ? ST_DONE : ST_LEAF_RD;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      rates_in     = rates_ff;
      frac_in      = frac_ff;
      total_in     = total_ff;
      prod_in      = prod_ff;
      t_in         = t_ff;
      node_in      = node_ff;
      lvl_in       = lvl_ff;
      ent_in       = ent_ff;
      occ_in       = occ_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      delta_in     = delta_ff;
      zero_in      = zero_ff;
      d_in         = d_ff;
      p_in         = p_ff;
      res_kind_in  = res_kind_ff;
      res_site_in  = res_site_ff;
      res_noev_in  = res_noev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_site_in  = rsp_site_ff;
      rsp_total_in = rsp_total_ff;
      rsp_noev_in  = rsp_noev_ff;
      ram_we       = 1'b0;
      ram_waddr    = node_ff;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = AW'(1);

      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_BIND:    rates_in.bind_rate    = csr_data;
            CSR_REBIND:  rates_in.rebind_rate  = csr_data;
            CSR_UNBIND:  rates_in.unbind_rate  = csr_data;
            CSR_HOP:     rates_in.hop_rate     = csr_data;
            CSR_RECOVER: rates_in.recover_rate = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_SWEEP: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(pspan) | AW'(p_ff);
            ram_wdata = {1'b0, zero_ff ? '0 : sweep_value};
            if (d_ff == '0) begin
               total_in = sweep_value;
            end
            if (sweep_plast) begin
               d_in = d_ff + LW'(1);
               p_in = '0;
            end else begin
               p_in = p_ff + LV'(1);
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               frac_in     = req_tdata;
               res_noev_in = 1'b0;
               res_kind_in = KIND_BIND;
               res_site_in = '0;
               zero_in     = 1'b0;
               d_in        = '0;
               p_in        = '0;
               ram_re      = (req_tuser[0] == CMD_DRAW);
            end
         end
         ST_ROOT: begin
            total_in = rd_sum;
            prod_in  = frac_ff * rd_sum;
            if (rd_sum == '0) begin
               res_noev_in = 1'b1;
            end
         end
         ST_MUL: begin
            t_in      = prod_ff[FRAC_W +: SUM_W];
            node_in   = AW'(1);
            lvl_in    = '0;
            ram_re    = 1'b1;
            ram_raddr = AW'(2);
         end
         ST_DESC: begin
            node_in = child;
            if (!go_left) begin
               t_in = t_ff - rd_sum;
            end
            if (lvl_ff == LW'(LV - 1)) begin
               ent_in = child[LV-1:0];
               cnt_in = '0;
            end else begin
               lvl_in    = lvl_ff + LW'(1);
               ram_re    = 1'b1;
               ram_raddr = {child[AW-2:0], 1'b0};
            end
         end
         ST_OCC: begin
            res_kind_in = kind_type'(ent_ff[1:0]);
            res_site_in = SITE_OUT_W'(slot - SLOT_W'(1));
            if (cnt_ff != 2'd0) begin
               occ_in[cnt_ff - 2'd1] = ram_rdata[DW-1];
            end
            if (cnt_ff != 2'd3) begin
               ram_re    = 1'b1;
               ram_raddr = {1'b1, occ_slot, 2'b00};
               cnt_in    = cnt_ff + 2'd1;
            end else begin
               op_in = '0;
            end
         end
         ST_LEAF_RD: begin
            if (op_ok) begin
               ram_re    = 1'b1;
               ram_raddr = {1'b1, tslot, op.act};
               node_in   = {1'b1, tslot, op.act};
            end else begin
               op_in = op_ff + OP_W'(1);
            end
         end
         ST_LEAF: begin
            if (!leaf_same) begin
               ram_we    = 1'b1;
               ram_waddr = node_ff;
               ram_wdata = leaf_new;
               ram_re    = 1'b1;
               ram_raddr = node_ff >> 1;
               node_in   = node_ff >> 1;
               delta_in  = SUM_W'(op.value) - rd_sum;
            end else begin
               op_in = op_ff + OP_W'(1);
            end
         end
         ST_WALK: begin
            ram_we    = 1'b1;
            ram_waddr = node_ff;
            ram_wdata = {ram_rdata[DW-1], rd_sum + delta_ff};
            if (node_ff == AW'(1)) begin
               op_in = op_ff + OP_W'(1);
            end else begin
               ram_re    = 1'b1;
               ram_raddr = node_ff >> 1;
               node_in   = node_ff >> 1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_site_in  = res_site_ff;
               rsp_total_in = TOTAL_W'(total_ff);
               rsp_noev_in  = res_noev_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         zero_ff      <= 1'b1;
         d_ff         <= '0;
         p_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         rates_ff     <= '{RATE_RESET, RATE_RESET, RATE_RESET, RATE_RESET, RATE_RESET};
         cnt_ff       <= '0;
         op_ff        <= '0;
         lvl_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         zero_ff      <= zero_in;
         d_ff         <= d_in;
         p_ff         <= p_in;
         rsp_valid_ff <= rsp_valid_in;
         rates_ff     <= rates_in;
         cnt_ff       <= cnt_in;
         op_ff        <= op_in;
         lvl_ff       <= lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      frac_ff      <= frac_in;
      total_ff     <= total_in;
      prod_ff      <= prod_in;
      t_ff         <= t_in;
      node_ff      <= node_in;
      ent_ff       <= ent_in;
      occ_ff       <= occ_in;
      delta_ff     <= delta_in;
      res_kind_ff  <= res_kind_in;
      res_site_ff  <= res_site_in;
      res_noev_ff  <= res_noev_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_site_ff  <= rsp_site_in;
      rsp_total_ff <= rsp_total_in;
      rsp_noev_ff  <= rsp_noev_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_total_ff, rsp_site_ff};
   assign rsp_tuser  = {rsp_noev_ff, rsp_kind_ff};

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ram_we)
      else $error("tree written while idle");

   a_no_node_zero: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ram_waddr != '0)
      else $error("write to unused tree node");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   a_noev_zero_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_noev_ff |-> rsp_total_ff == '0)
      else $error("no_event with nonzero total");

endmodule
